// ===== sv/bppnf_pkg.sv =====
package bppnf_pkg;

  localparam int CODE_BITS  = 64;
  localparam int MAX_DIGITS = 16;
  localparam int DIG_BITS   = 8;
  localparam int IDX_BITS   = $clog2(MAX_DIGITS);
  localparam int CNT_BITS   = $clog2(CODE_BITS);

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_CFG   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef logic [CODE_BITS-1:0] code_t;
  typedef logic [DIG_BITS-1:0]  dig_t;

  // sieve over a fixed range, folds to a constant table
  function automatic logic prime_ok(input logic [DIG_BITS-1:0] v);
    logic [255:0] comp;
    comp    = '0;
    comp[0] = 1'b1;
    comp[1] = 1'b1;
    for (int a = 2; a < 16; a++) begin
      for (int b = 2; b < 128; b++) begin
        if (a * b < 256) comp[a*b] = 1'b1;
      end
    end
    return !comp[v];
  endfunction

endpackage

// ===== sv/bppnf_div.sv =====
// bit-serial restoring divide of a code by the prime, one quotient bit a cycle
module bppnf_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     go,
  input  bppnf_pkg::code_t         dividend,
  input  bppnf_pkg::dig_t          divisor,
  output logic                     fin,
  output bppnf_pkg::code_t         quot,
  output bppnf_pkg::dig_t          rem
);

  logic [bppnf_pkg::CNT_BITS-1:0] cnt;
  logic                           run;
  logic [bppnf_pkg::DIG_BITS:0]   trial;

  assign trial = {rem, quot[bppnf_pkg::CODE_BITS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
      cnt <= '0;
    end else begin
      fin <= 1'b0;
      if (go) begin
        run  <= 1'b1;
        cnt  <= '0;
        quot <= dividend;
        rem  <= '0;
      end else if (run) begin
        if (trial >= {1'b0, divisor}) begin
          rem  <= bppnf_pkg::DIG_BITS'(trial - {1'b0, divisor});
          quot <= {quot[bppnf_pkg::CODE_BITS-2:0], 1'b1};
        end else begin
          rem  <= trial[bppnf_pkg::DIG_BITS-1:0];
          quot <= {quot[bppnf_pkg::CODE_BITS-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == bppnf_pkg::CNT_BITS'(bppnf_pkg::CODE_BITS - 1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/bppnf_mulmod.sv =====
// a*b mod p, double-and-add over the bits of b, msb first
module bppnf_mulmod (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  bppnf_pkg::dig_t    a,
  input  bppnf_pkg::dig_t    b,
  input  bppnf_pkg::dig_t    p,
  output logic               fin,
  output bppnf_pkg::dig_t    acc
);

  localparam int BC = $clog2(bppnf_pkg::DIG_BITS);

  bppnf_pkg::dig_t              a_r, b_r;
  logic [BC-1:0]                cnt;
  logic                         run;
  logic [bppnf_pkg::DIG_BITS:0] dbl, dred, sum;
  bppnf_pkg::dig_t              dr;

  always_comb begin
    dbl  = {acc, 1'b0};
    dred = (dbl >= {1'b0, p}) ? dbl - {1'b0, p} : dbl;
    dr   = dred[bppnf_pkg::DIG_BITS-1:0];
    sum  = {1'b0, dr} + {1'b0, a_r};
    if (b_r[bppnf_pkg::DIG_BITS-1]) begin
      if (sum >= {1'b0, p}) sum = sum - {1'b0, p};
    end else begin
      sum = {1'b0, dr};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
      cnt <= '0;
    end else begin
      fin <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
        a_r <= a;
        b_r <= b;
        acc <= '0;
      end else if (run) begin
        acc <= sum[bppnf_pkg::DIG_BITS-1:0];
        b_r <= {b_r[bppnf_pkg::DIG_BITS-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == BC'(bppnf_pkg::DIG_BITS - 1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/base_p_projective_normal_form.sv =====
// projective normal form of packed base-p codes. a beat is taken when start is
// high and busy is low; the result appears for exactly one cycle with done high
// and cannot be held off, so the receiver must take it then. for w digits and
// prime p, one item runs through w size multiplies, one range check, a serial
// divide plus handoff per digit, a linear search for the inverse of the lowest
// nonzero digit and, unless that inverse is one, a serial mod-p multiply plus
// accumulate per digit on re-encode, then the result beat. a code whose digits
// are all zero skips the search. bad prime or digit count is reported from idle.
// the user must write field_prime and digit_count through wr_en/wr_index/wr_data
// only while busy is low; the block itself does not enforce this.
module base_p_projective_normal_form (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  bppnf_pkg::code_t       code_in,
  input  logic                   last_in,
  output logic                   done,
  output bppnf_pkg::code_t       normal_code,
  output logic [1:0]             status,
  output logic                   last_out,
  input  logic                   wr_en,
  input  logic                   wr_index,
  input  logic [7:0]             wr_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SIZE  = 3'd1;
  localparam logic [2:0] S_RANGE = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_INV   = 3'd4;
  localparam logic [2:0] S_ENC   = 3'd5;
  localparam logic [2:0] S_MUL   = 3'd6;

  localparam logic REG_PRIME = 1'b0;
  localparam logic REG_WIDTH = 1'b1;

  localparam int CB = bppnf_pkg::CODE_BITS;
  localparam int DB = bppnf_pkg::DIG_BITS;

  logic [2:0]        state;
  bppnf_pkg::dig_t   field_prime;
  logic [4:0]        digit_count;

  bppnf_pkg::code_t  code_r, size, rem_code, res, prod;
  logic              last_r;
  logic [4:0]        cnt;
  bppnf_pkg::dig_t   digs [bppnf_pkg::MAX_DIGITS];
  bppnf_pkg::dig_t   lead, acc, k, scale, lead_nx;
  logic              found;
  logic [CB+DB-1:0]  pw;
  logic [DB:0]       acc_sum;

  logic              div_go, div_fin;
  bppnf_pkg::code_t  div_q;
  bppnf_pkg::dig_t   div_r;
  logic              mm_go, mm_fin;
  bppnf_pkg::dig_t   mm_res;
  bppnf_pkg::code_t  res_v;

  bppnf_div u_div (
    .clk(clk), .rst(rst), .go(div_go), .dividend(rem_code), .divisor(field_prime),
    .fin(div_fin), .quot(div_q), .rem(div_r)
  );

  bppnf_mulmod u_mm (
    .clk(clk), .rst(rst), .go(mm_go), .a(digs[cnt[bppnf_pkg::IDX_BITS-1:0]]), .b(scale),
    .p(field_prime), .fin(mm_fin), .acc(mm_res)
  );

  assign busy    = (state != S_IDLE);
  // running power of the prime, overflow shows in the top byte
  assign pw      = (CB+DB)'(size) * (CB+DB)'(field_prime);
  assign lead_nx = found ? lead : div_r;
  assign acc_sum = {1'b0, acc} + {1'b0, lead};
  assign res_v   = prod + CB'(mm_res);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      field_prime <= 8'd2;
      digit_count <= 5'd1;
    end else if (wr_en) begin
      case (wr_index)
        REG_PRIME: field_prime <= wr_data;
        REG_WIDTH: digit_count <= wr_data[4:0];
        default:   ;
      endcase
    end
  end

  // digit store, one digit written per divide
  always_ff @(posedge clk) begin
    if (state == S_DIV && div_fin) digs[cnt[bppnf_pkg::IDX_BITS-1:0]] <= div_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      div_go <= 1'b0;
      mm_go  <= 1'b0;
      found  <= 1'b0;
      cnt    <= '0;
    end else begin
      done   <= 1'b0;
      div_go <= 1'b0;
      mm_go  <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            code_r <= code_in;
            last_r <= last_in;
            size   <= CB'(1);
            cnt    <= '0;
            found  <= 1'b0;
            if (!bppnf_pkg::prime_ok(field_prime) || digit_count == 5'd0 ||
                digit_count > 5'(bppnf_pkg::MAX_DIGITS)) begin
              normal_code <= '0;
              status      <= bppnf_pkg::ST_CFG;
              last_out    <= last_in;
              done        <= 1'b1;
            end else begin
              state <= S_SIZE;
            end
          end
        end
        S_SIZE: begin
          if (pw[CB+DB-1:CB] != '0) begin
            normal_code <= '0;
            status      <= bppnf_pkg::ST_CFG;
            last_out    <= last_r;
            done        <= 1'b1;
            state       <= S_IDLE;
          end else begin
            size <= pw[CB-1:0];
            if (cnt == digit_count - 5'd1) begin
              cnt   <= '0;
              state <= S_RANGE;
            end else begin
              cnt <= cnt + 5'd1;
            end
          end
        end
        S_RANGE: begin
          if (code_r >= size) begin
            normal_code <= '0;
            status      <= bppnf_pkg::ST_RANGE;
            last_out    <= last_r;
            done        <= 1'b1;
            state       <= S_IDLE;
          end else begin
            rem_code <= code_r;
            div_go   <= 1'b1;
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_fin) begin
            rem_code <= div_q;
            if (!found && div_r != '0) begin
              lead  <= div_r;
              found <= 1'b1;
            end
            if (cnt == digit_count - 5'd1) begin
              if (found || div_r != '0) begin
                acc   <= lead_nx;
                k     <= DB'(1);
                state <= S_INV;
              end else begin
                // all digits zero
                normal_code <= '0;
                status      <= bppnf_pkg::ST_OK;
                last_out    <= last_r;
                done        <= 1'b1;
                state       <= S_IDLE;
              end
            end else begin
              cnt    <= cnt + 5'd1;
              div_go <= 1'b1;
            end
          end
        end
        S_INV: begin
          // walk k*lead mod p until it reaches one
          if (acc == DB'(1)) begin
            scale <= k;
            if (k == DB'(1)) begin
              normal_code <= code_r;
              status      <= bppnf_pkg::ST_OK;
              last_out    <= last_r;
              done        <= 1'b1;
              state       <= S_IDLE;
            end else begin
              res   <= '0;
              state <= S_ENC;
            end
          end else begin
            acc <= (acc_sum >= {1'b0, field_prime}) ?
                   DB'(acc_sum - {1'b0, field_prime}) : acc_sum[DB-1:0];
            k   <= k + DB'(1);
          end
        end
        S_ENC: begin
          prod  <= CB'(res * CB'(field_prime));
          mm_go <= 1'b1;
          state <= S_MUL;
        end
        S_MUL: begin
          if (mm_fin) begin
            if (cnt == 5'd0) begin
              normal_code <= res_v;
              status      <= bppnf_pkg::ST_OK;
              last_out    <= last_r;
              done        <= 1'b1;
              state       <= S_IDLE;
            end else begin
              res   <= res_v;
              cnt   <= cnt - 5'd1;
              state <= S_ENC;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result beat carries one of the defined status codes
  a_status_known: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == bppnf_pkg::ST_OK || status == bppnf_pkg::ST_CFG ||
              status == bppnf_pkg::ST_RANGE))
    else $error("result beat with unknown status");

  // any error beat carries a zero code
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != bppnf_pkg::ST_OK) |-> normal_code == '0)
    else $error("error beat with nonzero code");

  // a result beat always leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while still busy");

  // the two serial units are never kicked together
  a_one_unit: assert property (@(posedge clk) disable iff (rst) !(div_go && mm_go))
    else $error("divider and multiplier started together");

endmodule
